// ===== src/recent_region_table_bounding_box_unit_assert.svh =====
// Assertion macros for the recent region table RTL.
// Each macro expects clk and arst_n in scope.
`ifndef RECENT_REGION_TABLE_BOUNDING_BOX_UNIT_ASSERT_SVH
`define RECENT_REGION_TABLE_BOUNDING_BOX_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RRTB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRTB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rrtb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rrtb_pkg;

	// Fixed field widths
	localparam int ID_W   = 32;
	localparam int WIN_W  = 8;
	localparam int SLOT_W = 4;

	// Parameter defaults
	localparam int DEF_TABLE_ENTRIES = 16;
	localparam int DEF_COORD_BITS    = 16;

	// Window register value after reset
	localparam logic [WIN_W-1:0] WIN_RESET = 8'd4;

	// Item kinds carried on tuser
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Control from the sequencer to the scan accumulator
	typedef struct packed {
		logic clear;
		logic en;
	} rrtb_acc_ctl_t;

endpackage

`default_nettype wire

// ===== src/recent_region_table_bounding_box_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Recent region table with bounding-box advice.
// Input channel s_*: one beat per item. tuser carries the kind (add or query),
// tdata carries the frame id and the four rectangle coordinates.
// Output channel m_*: exactly one beat per input item, in order. An add returns
// hit and the slot refreshed or replaced; a query returns the bounding box of
// recent entries, right/bottom floored at 0, or the last box with box_fresh=0.
// cfg_wr_en/cfg_wr_data write the recent window; write only while idle.
// Flow: one item at a time. The table sits in a single-port-read RAM and is
// scanned one entry per cycle; an add writes back in the cycle its result
// loads. The next item can be taken in the cycle after the result loads; no
// new item is accepted while one is still in the scan.
// s_tready is high whenever the sequencer is idle, even while a result waits
// in the output register. If m_tready stays low, the next item scans and then
// holds until the output register frees up.
// Reset: table entries read as zero through per-entry valid bits (no clearing
// pass), the previous box is all minus one, the window is 4.
`include "recent_region_table_bounding_box_unit_assert.svh"

module recent_region_table_bounding_box_unit #(
	parameter int TABLE_ENTRIES = rrtb_pkg::DEF_TABLE_ENTRIES,
	parameter int COORD_BITS    = rrtb_pkg::DEF_COORD_BITS
) (
	input  wire logic                                               clk,
	input  wire logic                                               arst_n,
	// config: recent window
	input  wire logic                                               cfg_wr_en,
	input  wire logic [rrtb_pkg::WIN_W-1:0]                         cfg_wr_data,
	// input items
	input  wire logic                                               s_tvalid,
	output logic                                                    s_tready,
	// tdata: frame_id, region_left, region_top, region_right, region_bottom
	input  wire logic [((rrtb_pkg::ID_W+4*COORD_BITS+7)/8)*8-1:0]   s_tdata,
	// tuser: op
	input  wire logic                                               s_tuser,
	// results
	output logic                                                    m_tvalid,
	input  wire logic                                               m_tready,
	// tdata: hit, slot, adv_left, adv_top, adv_right, adv_bottom, box_fresh
	output logic      [((rrtb_pkg::SLOT_W+2+4*COORD_BITS+7)/8)*8-1:0] m_tdata
);
	import rrtb_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int CB     = COORD_BITS;
	localparam int BOX_W  = 4 * CB;
	localparam int ENT_W  = BOX_W + ID_W;
	localparam int OUT_W  = SLOT_W + 2 + BOX_W;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                rd_vld_s1;
	logic                ent_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [WIN_W-1:0]    win_q;
	logic [BOX_W-1:0]    prev_box_q;
	logic                m_tvalid_q;
	logic [OUT_TW-1:0]   m_tdata_q;

	logic                op_q;
	logic [ID_W-1:0]     fid_q;
	logic [BOX_W-1:0]    key_q;

	logic                s_accept;
	logic                rd_en;
	logic                out_free;
	logic                out_load;
	logic [IDX_W-1:0]    rd_addr;
	logic [ENT_W-1:0]    ram_rdata;
	logic [ENT_W-1:0]    ent;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [ENT_W-1:0]    ram_wdata;

	rrtb_acc_ctl_t       acc_ctl;
	logic                match;
	logic [IDX_W-1:0]    match_idx;
	logic [IDX_W-1:0]    min_idx;
	logic                found;
	logic [BOX_W-1:0]    acc_box;

	logic [IDX_W-1:0]        res_idx;
	logic [IDX_W+SLOT_W-1:0] res_idx_ext;
	logic [SLOT_W-1:0]       res_slot;
	logic                    res_hit;
	logic [BOX_W-1:0]        res_box;
	logic                    res_fresh;
	logic [OUT_TW-1:0]       res_data;

	// Handshake
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_FINISH) && out_free;

	// Table read sweep, one entry per cycle
	assign rd_en   = (state_q == ST_SCAN) && (cnt_q != CNT_W'(TABLE_ENTRIES));
	assign rd_addr = cnt_q[IDX_W-1:0];
	assign ent     = ent_vld_s1 ? ram_rdata : '0;

	// Write back on an add: refresh the hit or replace the least recent
	assign res_idx   = match ? match_idx : min_idx;
	assign ram_we    = out_load && (op_q == OP_ADD);
	assign ram_waddr = res_idx;
	assign ram_wdata = {fid_q, key_q};

	rrtb_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	assign acc_ctl.clear = s_accept;
	assign acc_ctl.en    = rd_vld_s1;

	rrtb_acc #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.COORD_BITS   (COORD_BITS)
	) u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (acc_ctl),
		.idx        (rd_idx_s1),
		.ent        (ent),
		.key        (key_q),
		.win        (win_q),
		.fid        (fid_q),
		.match_q    (match),
		.match_idx_q(match_idx),
		.min_idx_q  (min_idx),
		.found_q    (found),
		.box_q      (acc_box)
	);

	// Build the result beat
	assign res_idx_ext = {{SLOT_W{1'b0}}, res_idx};
	always_comb begin
		res_hit   = 1'b0;
		res_slot  = '0;
		res_box   = '0;
		res_fresh = 1'b0;
		if (op_q == OP_ADD) begin
			res_hit  = match;
			res_slot = res_idx_ext[SLOT_W-1:0];
		end else begin
			res_box   = found ? acc_box : prev_box_q;
			res_fresh = found;
		end
		res_data = OUT_TW'({res_fresh, res_box, res_slot, res_hit});
	end

	// Window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_RESET;
		end else if (cfg_wr_en) begin
			win_q <= cfg_wr_data;
		end
	end

	// Entry valid bits: unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	// Latch the item and align read-side tags with the RAM data
	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_q  <= s_tuser;
			fid_q <= s_tdata[ID_W-1:0];
			key_q <= s_tdata[ID_W +: BOX_W];
		end
		rd_idx_s1  <= rd_addr;
		ent_vld_s1 <= valid_q[rd_addr];
	end

	// Sequencer, previous box and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			prev_box_q <= '1;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (!rd_vld_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tdata_q  <= res_data;
						if ((op_q == OP_QUERY) && found) begin
							prev_box_q <= acc_box;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks
	`RRTB_ASSERT_NEXT(a_accept_starts_scan, s_accept,
		(state_q == ST_SCAN) && (cnt_q == '0), "accepted item did not start a scan")
	`RRTB_ASSERT_NOW(a_write_only_add, ram_we,
		(state_q == ST_FINISH) && (op_q == OP_ADD), "table write outside add write-back")
	`RRTB_ASSERT_NOW(a_finish_after_drain, state_q == ST_FINISH,
		!rd_vld_s1 && !rd_en, "result formed before the scan drained")
	`RRTB_ASSERT_NOW(a_no_overwrite, out_load,
		!m_tvalid_q || m_tready, "result overwrote a pending beat")

endmodule

`default_nettype wire

// ===== src/rrtb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrtb_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/rrtb_acc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rrtb_acc #(
	parameter int TABLE_ENTRIES = rrtb_pkg::DEF_TABLE_ENTRIES,
	parameter int COORD_BITS    = rrtb_pkg::DEF_COORD_BITS
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire rrtb_pkg::rrtb_acc_ctl_t                      ctl,
	input  wire logic [$clog2(TABLE_ENTRIES)-1:0]             idx,
	input  wire logic [4*COORD_BITS+rrtb_pkg::ID_W-1:0]       ent,
	input  wire logic [4*COORD_BITS-1:0]                      key,
	input  wire logic [rrtb_pkg::WIN_W-1:0]                   win,
	input  wire logic [rrtb_pkg::ID_W-1:0]                    fid,
	output logic                                              match_q,
	output logic      [$clog2(TABLE_ENTRIES)-1:0]             match_idx_q,
	output logic      [$clog2(TABLE_ENTRIES)-1:0]             min_idx_q,
	output logic                                              found_q,
	output logic      [4*COORD_BITS-1:0]                      box_q
);
	import rrtb_pkg::*;

	localparam int CB    = COORD_BITS;

	logic signed [CB-1:0] e_l, e_t, e_r, e_b;
	logic signed [CB-1:0] b_l, b_t, b_r, b_b;
	logic [ID_W-1:0]      e_id;
	logic [ID_W-1:0]      min_id_q;
	logic [ID_W:0]        age_sum;
	logic                 is_match, is_recent, take_min;

	// Unpack the entry and the running box
	assign e_l  = $signed(ent[0*CB +: CB]);
	assign e_t  = $signed(ent[1*CB +: CB]);
	assign e_r  = $signed(ent[2*CB +: CB]);
	assign e_b  = $signed(ent[3*CB +: CB]);
	assign e_id = ent[4*CB +: ID_W];
	assign b_l  = $signed(box_q[0*CB +: CB]);
	assign b_t  = $signed(box_q[1*CB +: CB]);
	assign b_r  = $signed(box_q[2*CB +: CB]);
	assign b_b  = $signed(box_q[3*CB +: CB]);

	// Compare against the item: exact match, recency, least id
	assign is_match  = (ent[4*CB-1:0] == key);
	assign age_sum   = {1'b0, e_id} + {{(ID_W+1-WIN_W){1'b0}}, win};
	assign is_recent = (age_sum > {1'b0, fid});
	assign take_min  = (idx == '0) || (e_id < min_id_q);

	// Control flags of the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			match_q <= 1'b0;
			found_q <= 1'b0;
		end else if (ctl.en) begin
			if (is_match) begin
				match_q <= 1'b1;
			end
			if (is_recent) begin
				found_q <= 1'b1;
			end
		end
	end

	// Accumulate first match, least id and the recent box
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			box_q[2*CB +: CB] <= '0;
			box_q[3*CB +: CB] <= '0;
		end else if (ctl.en) begin
			if (is_match && !match_q) begin
				match_idx_q <= idx;
			end
			if (take_min) begin
				min_id_q  <= e_id;
				min_idx_q <= idx;
			end
			if (is_recent) begin
				if (!found_q || (e_l < b_l)) begin
					box_q[0*CB +: CB] <= e_l;
				end
				if (!found_q || (e_t < b_t)) begin
					box_q[1*CB +: CB] <= e_t;
				end
				if (e_r > b_r) begin
					box_q[2*CB +: CB] <= e_r;
				end
				if (e_b > b_b) begin
					box_q[3*CB +: CB] <= e_b;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb_recent_region_table_bounding_box_unit.sv =====
`timescale 1ns / 1ps

module tb_recent_region_table_bounding_box_unit;

	localparam int TABLE_ENTRIES = 16;
	localparam int COORD_BITS    = 16;
	localparam int IN_W  = ((rrtb_pkg::ID_W + 4*COORD_BITS + 7)/8)*8;
	localparam int OUT_W = ((rrtb_pkg::SLOT_W + 2 + 4*COORD_BITS + 7)/8)*8;
	localparam int RES_W = rrtb_pkg::SLOT_W + 2 + 4*COORD_BITS;
	localparam int POOL_SIZE    = 24;
	localparam int PHASE_ITEMS  = 305;
	localparam int DRAIN_CYCLES = 40;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// left sits in the lowest bits
	typedef struct packed {
		coord_t bottom;
		coord_t right;
		coord_t top;
		coord_t left;
	} rect_t;

	typedef struct packed {
		rect_t                    rect;
		logic [rrtb_pkg::ID_W-1:0] id;
	} region_entry_t;

	typedef struct packed {
		logic                      op;
		logic [rrtb_pkg::ID_W-1:0] fid;
		rect_t                     rect;
	} region_item_t;

	// hit sits in the lowest bit
	typedef struct packed {
		logic                        box_fresh;
		coord_t                      adv_bottom;
		coord_t                      adv_right;
		coord_t                      adv_top;
		coord_t                      adv_left;
		logic [rrtb_pkg::SLOT_W-1:0] slot;
		logic                        hit;
	} advice_t;

	// Shadow of the region table and the advised-box register
	class region_advice_scoreboard;
		region_entry_t               entries[TABLE_ENTRIES];
		rect_t                       last_box;
		logic [rrtb_pkg::WIN_W-1:0]  window;
		advice_t                     pending_advice[$];
		int errors, n_items, n_adds, n_hits, n_queries, n_stale, n_checked;

		function new();
			foreach (entries[i]) entries[i] = '0;
			last_box = '1;
			window   = rrtb_pkg::WIN_RESET;
		endfunction

		// Work out the advice an item earns and update the shadow state
		function advice_t predict_advice(region_item_t it);
			advice_t res;
			logic    found;
			int      pick;
			rect_t   box;
			res   = '0;
			found = 1'b0;
			pick  = 0;
			box   = '0;
			if (it.op == rrtb_pkg::OP_ADD) begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (!found && entries[i].rect == it.rect) begin
						found = 1'b1;
						pick  = i;
					end
				end
				if (!found) begin
					for (int i = 1; i < TABLE_ENTRIES; i++)
						if (entries[i].id < entries[pick].id) pick = i;
					entries[pick].rect = it.rect;
				end
				entries[pick].id = it.fid;
				res.hit  = found;
				res.slot = pick[rrtb_pkg::SLOT_W-1:0];
			end else begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					// recency sum is one bit wider so it never wraps
					if (33'(entries[i].id) + 33'(window) > 33'(it.fid)) begin
						if (!found || entries[i].rect.left < box.left)
							box.left = entries[i].rect.left;
						if (!found || entries[i].rect.top < box.top)
							box.top = entries[i].rect.top;
						if (entries[i].rect.right > box.right)
							box.right = entries[i].rect.right;
						if (entries[i].rect.bottom > box.bottom)
							box.bottom = entries[i].rect.bottom;
						found = 1'b1;
					end
				end
				if (found) last_box = box;
				res.adv_left   = last_box.left;
				res.adv_top    = last_box.top;
				res.adv_right  = last_box.right;
				res.adv_bottom = last_box.bottom;
				res.box_fresh  = found;
			end
			return res;
		endfunction

		function void note_item(region_item_t it);
			advice_t res;
			res = predict_advice(it);
			pending_advice.push_back(res);
			n_items++;
			if (it.op == rrtb_pkg::OP_ADD) begin
				n_adds++;
				if (res.hit) n_hits++;
			end else begin
				n_queries++;
				if (!res.box_fresh) n_stale++;
			end
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_W-1:0] beat);
			advice_t want;
			advice_t got;
			if (pending_advice.size() == 0) begin
				$display("%0t ns: unexpected result beat, expected none, actual %h", $time, beat);
				errors++;
				return;
			end
			want = pending_advice.pop_front();
			got  = beat[RES_W-1:0];
			n_checked++;
			compare_field("hit", want.hit, got.hit);
			compare_field("slot", want.slot, got.slot);
			compare_field("adv_left", want.adv_left, got.adv_left);
			compare_field("adv_top", want.adv_top, got.adv_top);
			compare_field("adv_right", want.adv_right, got.adv_right);
			compare_field("adv_bottom", want.adv_bottom, got.adv_bottom);
			compare_field("box_fresh", want.box_fresh, got.box_fresh);
			compare_field("tdata padding", 0, beat[OUT_W-1:RES_W]);
		endfunction
	endclass

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        cfg_wr_en   = 1'b0;
	logic [rrtb_pkg::WIN_W-1:0]  cfg_wr_data = '0;
	logic                        s_tvalid    = 1'b0;
	logic                        s_tready;
	// tdata: frame_id, region_left, region_top, region_right, region_bottom
	logic [IN_W-1:0]             s_tdata     = '0;
	// tuser: op
	logic                        s_tuser     = 1'b0;
	logic                        m_tvalid;
	logic                        m_tready    = 1'b0;
	// tdata: hit, slot, adv_left, adv_top, adv_right, adv_bottom, box_fresh
	logic [OUT_W-1:0]            m_tdata;

	region_advice_scoreboard sb = new();

	int                         send_gap_pct   = 0;
	int                         recv_stall_pct = 0;
	logic                       sink_hold      = 1'b0;
	logic [rrtb_pkg::ID_W-1:0]  frame_now      = 32'd50;
	rect_t                      rect_pool[POOL_SIZE];
	int                         n_windows      = 1;

	recent_region_table_bounding_box_unit #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.COORD_BITS   (COORD_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	always #2 clk = ~clk;

	// Hard stop in case the block hangs
	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

	// Sink side: stall at random, check every beat taken
	always begin
		@(negedge clk);
		m_tready <= !sink_hold && ($urandom_range(0, 99) >= recv_stall_pct);
		@(posedge clk);
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	function automatic region_item_t make_item(logic op, logic [31:0] fid,
			int l, int t, int r, int b);
		region_item_t it;
		it.op          = op;
		it.fid         = fid;
		it.rect.left   = coord_t'(l);
		it.rect.top    = coord_t'(t);
		it.rect.right  = coord_t'(r);
		it.rect.bottom = coord_t'(b);
		return it;
	endfunction

	// Half small coordinates around zero, half anywhere
	function automatic rect_t random_rect();
		rect_t rc;
		if ($urandom_range(0, 1)) begin
			rc.left   = coord_t'(int'($urandom_range(0, 128)) - 64);
			rc.top    = coord_t'(int'($urandom_range(0, 128)) - 64);
			rc.right  = coord_t'(int'($urandom_range(0, 128)) - 64);
			rc.bottom = coord_t'(int'($urandom_range(0, 128)) - 64);
		end else begin
			rc = rect_t'({$urandom, $urandom});
		end
		return rc;
	endfunction

	// Offer one beat after a random gap, hold it until taken
	task automatic send_item(region_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {it.rect, it.fid};
		s_tuser  <= it.op;
		do @(posedge clk); while (!s_tready);
		sb.note_item(it);
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_advice.size() != 0) @(posedge clk);
	endtask

	task automatic write_window(logic [rrtb_pkg::WIN_W-1:0] w);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= w;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		sb.window = w;
		n_windows++;
	endtask

	task automatic set_idling(int mode);
		case (mode)
			0: begin
				send_gap_pct   = 35;
				recv_stall_pct = 61;
			end
			1: begin
				send_gap_pct   = 61;
				recv_stall_pct = 35;
			end
			default: begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	// Edge cases right after reset, with the reset window
	task automatic run_directed();
		send_item(make_item(rrtb_pkg::OP_QUERY, 32'd10, 32767, -32768, 21845, -21846));
		send_item(make_item(rrtb_pkg::OP_ADD, 32'd5, 0, 0, 0, 0));
		send_item(make_item(rrtb_pkg::OP_ADD, 32'd6, -32768, -32768, 32767, 32767));
		send_item(make_item(rrtb_pkg::OP_ADD, 32'd7, 32767, 32767, -32768, -32768));
		send_item(make_item(rrtb_pkg::OP_ADD, 32'd8, -5, -6, -1, -2));
		send_item(make_item(rrtb_pkg::OP_QUERY, 32'd8, -1, -1, -1, -1));
		send_item(make_item(rrtb_pkg::OP_QUERY, 32'd100, 0, 0, 0, 0));
		send_item(make_item(rrtb_pkg::OP_QUERY, 32'd11, 5, 5, 5, 5));
		send_item(make_item(rrtb_pkg::OP_ADD, 32'd20, -5, -6, -1, -2));
		send_item(make_item(rrtb_pkg::OP_ADD, 32'hFFFF_FFFF, 1, 2, 3, 4));
		send_item(make_item(rrtb_pkg::OP_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0));
		// fill the rest of the table up to the last slot
		for (int i = 0; i < 11; i++)
			send_item(make_item(rrtb_pkg::OP_ADD, 32'd30 + i,
				i * 100 - 500, 16'hAAAA, 16'h5555, i));
		send_item(make_item(rrtb_pkg::OP_ADD, 32'd40, 7, 7, 7, 7));
		send_item(make_item(rrtb_pkg::OP_QUERY, 32'd41, 0, 0, 0, 0));
	endtask

	// Frame-like traffic: repeated rectangles, queries near the counter, some noise
	task automatic run_random(int count);
		int           kind;
		int           idx;
		region_item_t it;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 30) frame_now += $urandom_range(0, 3);
			kind   = $urandom_range(0, 99);
			idx    = $urandom_range(0, POOL_SIZE - 1);
			it.op  = rrtb_pkg::OP_QUERY;
			it.fid = frame_now;
			it.rect = rect_t'({$urandom, $urandom});
			if (kind < 45) begin
				it.op   = rrtb_pkg::OP_ADD;
				it.rect = rect_pool[idx];
			end else if (kind < 70) begin
				it.fid = frame_now + $urandom_range(0, 32'(sb.window) + 2);
			end else if (kind < 78) begin
				rect_pool[idx] = random_rect();
				it.op   = rrtb_pkg::OP_ADD;
				it.rect = rect_pool[idx];
			end else if (kind < 84) begin
				// far ahead of every stored id
				it.fid = frame_now + $urandom_range(300, 100000);
			end else if (kind < 88) begin
				frame_now += $urandom_range(10, 600);
				it.fid = frame_now;
			end else begin
				it.op  = 1'($urandom_range(0, 1));
				it.fid = $urandom;
			end
			send_item(it);
		end
	endtask

	initial begin
		logic [rrtb_pkg::WIN_W-1:0] windows[6];
		windows[0] = 8'd1;
		windows[1] = 8'd255;
		windows[2] = 8'($urandom_range(5, 60));
		windows[3] = 8'd2;
		windows[4] = 8'($urandom_range(3, 12));
		windows[5] = 8'd255;
		foreach (rect_pool[i]) rect_pool[i] = random_rect();
		rect_pool[0] = '0;

		// Reset
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_idling(0);
		run_directed();
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_window(windows[ph]);
			set_idling(ph % 3);
			if (ph == 2) begin
				// long sink stall while the source keeps pushing
				fork
					begin
						repeat (60) @(posedge clk);
						sink_hold = 1'b1;
						repeat (500) @(posedge clk);
						sink_hold = 1'b0;
					end
				join_none
			end
			// cross the 32-bit frame id wrap
			if (ph == 4) frame_now = 32'hFFFF_FFF0;
			run_random(PHASE_ITEMS);
			drain();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d items (%0d adds, %0d hits; %0d queries, %0d stale) over %0d windows",
			sb.n_items, sb.n_adds, sb.n_hits, sb.n_queries, sb.n_stale, n_windows);
		$display("Results checked: %0d, mismatches: %0d", sb.n_checked, sb.errors);
		if (sb.errors == 0 && sb.pending_advice.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/rrtb_pkg.sv
src/rrtb_ram.sv
src/rrtb_acc.sv
src/recent_region_table_bounding_box_unit.sv
bench/tb_recent_region_table_bounding_box_unit.sv
